>>> rtl/core/prescaled_reload_timer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prescaled reload timer
// Clocked, reset-gated property shorthands used at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef PRESCALED_RELOAD_TIMER_UNIT_ASSERT_SVH
`define PRESCALED_RELOAD_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PRTU_ASSERT_SAME(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("prtu assertion failed");

// Next-cycle implication, checked out of reset
`define PRTU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("prtu assertion failed");

`endif

>>> rtl/core/prtu_pkg.sv
// ----------------------------------------------------------------------------
// Prescaled reload timer package
// Widths, request codes and register map shared by the timer RTL.
// ----------------------------------------------------------------------------
package prtu_pkg;

	// Width of the main counter and the reload registers
	localparam int CNT_W = 16;
	// Width of the prescaler registers and of the register data bus
	localparam int PSC_W = 16;
	localparam int DATA_W = 16;

	// Request kinds
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	// Register map
	typedef enum logic [2:0] {
		REG_CTRL   = 3'd0,
		REG_IRQ_EN = 3'd1,
		REG_STATUS = 3'd2,
		REG_EVENT  = 3'd3,
		REG_COUNT  = 3'd4,
		REG_PSC    = 3'd5,
		REG_RELOAD = 3'd6
	} reg_index_t;

	// Control register bit positions
	localparam int CTRL_EN_BIT  = 0;
	localparam int CTRL_BUF_BIT = 7;

endpackage

>>> rtl/core/prescaled_reload_timer_unit.sv
// ----------------------------------------------------------------------------
// Prescaled reload timer
// Up-counting timer with prescaler, auto-reload preload and update interrupt.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_axis channel: s_axis_tuser carries the request kind
// (tick, register write, register read) and the register index, s_axis_tdata
// the write value. Every request gives exactly one response on m_axis: the
// read value (zero for ticks and writes), the interrupt line after the request
// and a pulse bit that marks an update event caused by this request.
// A request accepted into the request register is processed as it moves into
// the response register, whose response is valid from then on. Throughput is
// one request per cycle while m_axis does not stall, set by the single stage
// holding the request ahead of the timer state update and response register.
// When m_axis stalls, the response register holds, the request register fills
// and then s_axis_tready drops; no request is lost or dropped.
// Reset (arst_n low) clears both stages and returns the timer to disabled,
// counter and prescaler zero, reload values all ones, flag and enable clear.
// ----------------------------------------------------------------------------
`include "prescaled_reload_timer_unit_assert.svh"

module prescaled_reload_timer_unit
	import prtu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] write_data
	input  logic [4:0]  s_axis_tuser,   // [1:0] opcode, [4:2] reg_index
	// Response channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [15:0] read_data, [16] irq, [17] update_pulse
);

	// Request stage
	logic              valid_s1;
	opcode_t           opcode_s1;
	reg_index_t        index_s1;
	logic [DATA_W-1:0] wdata_s1;

	// Response register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_rdata_q;
	logic              out_irq_q;
	logic              out_pulse_q;

	// Timer state
	logic              enable_q;
	logic              buffered_q;
	logic              irq_en_q;
	logic              flag_q;
	logic [CNT_W-1:0]  counter_q;
	logic [PSC_W-1:0]  psc_count_q;
	logic [PSC_W-1:0]  psc_preload_q;
	logic [PSC_W-1:0]  psc_active_q;
	logic [CNT_W-1:0]  reload_preload_q;
	logic [CNT_W-1:0]  reload_active_q;

	// Next timer state and response
	logic              enable_d;
	logic              buffered_d;
	logic              irq_en_d;
	logic              flag_d;
	logic [CNT_W-1:0]  counter_d;
	logic [PSC_W-1:0]  psc_count_d;
	logic [PSC_W-1:0]  psc_preload_d;
	logic [PSC_W-1:0]  psc_active_d;
	logic [CNT_W-1:0]  reload_preload_d;
	logic [CNT_W-1:0]  reload_active_d;
	logic [DATA_W-1:0] rdata_d;
	logic              pulse_d;

	logic              out_free;
	logic              advance;

	// Stage handshakes
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Capture request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= opcode_t'(s_axis_tuser[1:0]);
			index_s1  <= reg_index_t'(s_axis_tuser[4:2]);
			wdata_s1  <= s_axis_tdata;
		end
	end

	// Work out the timer update for the staged request
	always_comb begin
		enable_d         = enable_q;
		buffered_d       = buffered_q;
		irq_en_d         = irq_en_q;
		flag_d           = flag_q;
		counter_d        = counter_q;
		psc_count_d      = psc_count_q;
		psc_preload_d    = psc_preload_q;
		psc_active_d     = psc_active_q;
		reload_preload_d = reload_preload_q;
		reload_active_d  = reload_active_q;
		rdata_d          = '0;
		pulse_d          = 1'b0;
		case (opcode_s1)
			OP_TICK: begin
				if (enable_q) begin
					if (psc_count_q < psc_active_q) begin
						psc_count_d = psc_count_q + PSC_W'(1);
					end else begin
						psc_count_d = '0;
						if (counter_q >= reload_active_q) begin
							// Wrap: update event loads the prescaler shadow, and the reload shadow if buffered
							counter_d    = '0;
							psc_active_d = psc_preload_q;
							if (buffered_q) begin
								reload_active_d = reload_preload_q;
							end
							flag_d  = 1'b1;
							pulse_d = 1'b1;
						end else begin
							counter_d = counter_q + CNT_W'(1);
						end
					end
				end
			end
			OP_WRITE: begin
				case (index_s1)
					REG_CTRL: begin
						enable_d   = wdata_s1[CTRL_EN_BIT];
						buffered_d = wdata_s1[CTRL_BUF_BIT];
					end
					REG_IRQ_EN: begin
						irq_en_d = wdata_s1[0];
					end
					REG_STATUS: begin
						flag_d = flag_q & wdata_s1[0];
					end
					REG_EVENT: begin
						// Software update restarts both counters
						if (wdata_s1[0]) begin
							counter_d       = '0;
							psc_count_d     = '0;
							psc_active_d    = psc_preload_q;
							reload_active_d = reload_preload_q;
							flag_d          = 1'b1;
							pulse_d         = 1'b1;
						end
					end
					REG_COUNT: begin
						counter_d = CNT_W'(wdata_s1);
					end
					REG_PSC: begin
						psc_preload_d = PSC_W'(wdata_s1);
					end
					REG_RELOAD: begin
						reload_preload_d = CNT_W'(wdata_s1);
						if (!buffered_q) begin
							reload_active_d = CNT_W'(wdata_s1);
						end
					end
					default: begin
					end
				endcase
			end
			OP_READ: begin
				case (index_s1)
					REG_CTRL: begin
						rdata_d[CTRL_EN_BIT]  = enable_q;
						rdata_d[CTRL_BUF_BIT] = buffered_q;
					end
					REG_IRQ_EN: rdata_d[0] = irq_en_q;
					REG_STATUS: rdata_d[0] = flag_q;
					REG_COUNT:  rdata_d    = DATA_W'(counter_q);
					REG_PSC:    rdata_d    = DATA_W'(psc_preload_q);
					REG_RELOAD: rdata_d    = DATA_W'(reload_preload_q);
					default:    rdata_d    = '0;
				endcase
			end
			default: begin
			end
		endcase
	end

	// Commit timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q         <= 1'b0;
			buffered_q       <= 1'b0;
			irq_en_q         <= 1'b0;
			flag_q           <= 1'b0;
			counter_q        <= '0;
			psc_count_q      <= '0;
			psc_preload_q    <= '0;
			psc_active_q     <= '0;
			reload_preload_q <= '1;
			reload_active_q  <= '1;
		end else if (advance) begin
			enable_q         <= enable_d;
			buffered_q       <= buffered_d;
			irq_en_q         <= irq_en_d;
			flag_q           <= flag_d;
			counter_q        <= counter_d;
			psc_count_q      <= psc_count_d;
			psc_preload_q    <= psc_preload_d;
			psc_active_q     <= psc_active_d;
			reload_preload_q <= reload_preload_d;
			reload_active_q  <= reload_active_d;
		end
	end

	// Hold response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rdata_q <= rdata_d;
			out_irq_q   <= flag_d & irq_en_d;
			out_pulse_q <= pulse_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_pulse_q, out_irq_q, out_rdata_q};

	// Update event always leaves the flag raised
	`PRTU_ASSERT_NEXT(a_pulse_sets_flag, clk, arst_n, advance && pulse_d, flag_q)

	// Staged request waits while the response register is blocked
	`PRTU_ASSERT_NEXT(a_stage_holds, clk, arst_n, valid_s1 && !out_free, valid_s1)

	// Timer state moves only when a request is processed
	`PRTU_ASSERT_NEXT(a_state_quiet, clk, arst_n, !advance,
		$stable(counter_q) && $stable(flag_q) && $stable(psc_count_q))

	// Unbuffered reload write takes effect in the active reload at once
	`PRTU_ASSERT_NEXT(a_reload_direct, clk, arst_n,
		advance && opcode_s1 == OP_WRITE && index_s1 == REG_RELOAD && !buffered_q,
		reload_active_q == reload_preload_q)

endmodule
